FILE: hdl/ctsk_pkg.sv
package ctsk_pkg;

    localparam logic [4:0]  HOURS_MAX    = 5'd23;
    localparam logic [5:0]  MINSEC_MAX   = 6'd59;
    localparam logic [15:0] BLINK_RESET  = 16'd500;
    localparam logic [15:0] TICKS_MAX    = 16'hFFFF;

    localparam logic [1:0] CUR_HOURS     = 2'd0;
    localparam logic [1:0] CUR_MINUTES   = 2'd1;
    localparam logic [1:0] CUR_SECONDS   = 2'd2;

    localparam logic [4:0] RESET_HOURS   = 5'd0;
    localparam logic [5:0] RESET_MINUTES = 6'd4;
    localparam logic [5:0] RESET_SECONDS = 6'd32;

    localparam logic [2:0] BTN_NONE      = 3'd0;
    localparam logic [2:0] BTN_RIGHT     = 3'd1;
    localparam logic [2:0] BTN_LEFT      = 3'd2;
    localparam logic [2:0] BTN_UP        = 3'd3;
    localparam logic [2:0] BTN_DOWN      = 3'd4;
    localparam logic [2:0] BTN_CONFIRM   = 3'd5;

    typedef struct packed {
        logic btn_right;
        logic btn_left;
        logic btn_up;
        logic btn_down;
        logic btn_confirm;
    } t_in_item;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [1:0] cursor;
        logic       field_blanked;
        logic       led_on;
        logic [2:0] last_button;
    } t_out_item;

endpackage

FILE: hdl/clock_time_set_keypad.sv
// Channel  | Direction | Handshake              | Payload
// in       | input     | i_in_valid / o_in_stall | i_in_data   (ctsk_pkg::t_in_item)
// out      | output    | o_out_valid / i_out_stall | o_out_data (ctsk_pkg::t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data  (blink_period, 16 bit)
//
// One beat per cycle sustained while i_out_stall is low; each input beat goes to the
// input register, then through one pass of edge detect, cursor/time update and blink
// counter into the result register.
// Synchronous active-low reset loads the power-up time 00:04:32, cursor on seconds.
// A stall on the output holds the result register; the input register absorbs one
// more beat before o_in_stall rises.
module clock_time_set_keypad (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ctsk_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ctsk_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);

    logic                r_in_valid;
    ctsk_pkg::t_in_item  r_in;
    logic                r_out_valid;
    ctsk_pkg::t_out_item r_out;

    logic [15:0] r_period;
    logic [4:0]  r_prev;
    logic [1:0]  r_cursor;
    logic [4:0]  r_hours;
    logic [5:0]  r_minutes;
    logic [5:0]  r_seconds;
    logic        r_blank;
    logic [15:0] r_elapsed;
    logic        r_led;
    logic [2:0]  r_last;

    logic [4:0]  now_btn;
    logic [4:0]  rise;
    logic [1:0]  n_cursor;
    logic [4:0]  n_hours;
    logic [5:0]  n_minutes;
    logic [5:0]  n_seconds;
    logic        n_blank;
    logic [15:0] n_elapsed;
    logic        n_led;
    logic [2:0]  n_last;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign now_btn = {r_in.btn_confirm, r_in.btn_down, r_in.btn_up,
                      r_in.btn_left, r_in.btn_right};
    assign rise    = now_btn & ~r_prev;

    always_comb begin
        logic [15:0] ticks;
        n_cursor  = r_cursor;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_led     = r_led;
        n_last    = r_last;

        if (rise[0]) begin
            n_led    = ~n_led;
            n_last   = ctsk_pkg::BTN_RIGHT;
            n_cursor = (n_cursor == ctsk_pkg::CUR_SECONDS) ? ctsk_pkg::CUR_HOURS
                                                           : n_cursor + 2'd1;
        end
        if (rise[1]) begin
            n_led    = ~n_led;
            n_last   = ctsk_pkg::BTN_LEFT;
            n_cursor = (n_cursor == ctsk_pkg::CUR_HOURS) ? ctsk_pkg::CUR_SECONDS
                                                         : n_cursor - 2'd1;
        end
        if (rise[2]) begin
            n_led  = ~n_led;
            n_last = ctsk_pkg::BTN_UP;
            case (n_cursor)
                ctsk_pkg::CUR_HOURS:
                    n_hours = (n_hours < ctsk_pkg::HOURS_MAX) ? n_hours + 5'd1 : 5'd0;
                ctsk_pkg::CUR_MINUTES:
                    n_minutes = (n_minutes < ctsk_pkg::MINSEC_MAX) ? n_minutes + 6'd1 : 6'd0;
                ctsk_pkg::CUR_SECONDS:
                    n_seconds = (n_seconds < ctsk_pkg::MINSEC_MAX) ? n_seconds + 6'd1 : 6'd0;
                default: ;
            endcase
        end
        if (rise[3]) begin
            n_led  = ~n_led;
            n_last = ctsk_pkg::BTN_DOWN;
            case (n_cursor)
                ctsk_pkg::CUR_HOURS:
                    n_hours = (n_hours != 5'd0 && n_hours <= ctsk_pkg::HOURS_MAX)
                              ? n_hours - 5'd1 : ctsk_pkg::HOURS_MAX;
                ctsk_pkg::CUR_MINUTES:
                    n_minutes = (n_minutes != 6'd0 && n_minutes <= ctsk_pkg::MINSEC_MAX)
                                ? n_minutes - 6'd1 : ctsk_pkg::MINSEC_MAX;
                ctsk_pkg::CUR_SECONDS:
                    n_seconds = (n_seconds != 6'd0 && n_seconds <= ctsk_pkg::MINSEC_MAX)
                                ? n_seconds - 6'd1 : ctsk_pkg::MINSEC_MAX;
                default: ;
            endcase
        end
        if (rise[4]) begin
            n_led  = ~n_led;
            n_last = ctsk_pkg::BTN_CONFIRM;
        end

        // saturate, then restart once the period is exceeded
        ticks = (r_elapsed != ctsk_pkg::TICKS_MAX) ? r_elapsed + 16'd1 : r_elapsed;
        if (ticks > r_period) begin
            n_blank   = ~r_blank;
            n_elapsed = 16'd0;
        end else begin
            n_blank   = r_blank;
            n_elapsed = ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= ctsk_pkg::BLINK_RESET;
            r_prev      <= 5'd0;
            r_cursor    <= ctsk_pkg::CUR_SECONDS;
            r_hours     <= ctsk_pkg::RESET_HOURS;
            r_minutes   <= ctsk_pkg::RESET_MINUTES;
            r_seconds   <= ctsk_pkg::RESET_SECONDS;
            r_blank     <= 1'b0;
            r_elapsed   <= 16'd0;
            r_led       <= 1'b0;
            r_last      <= ctsk_pkg::BTN_NONE;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_period <= i_cfg_data;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_prev      <= now_btn;
                r_cursor    <= n_cursor;
                r_hours     <= n_hours;
                r_minutes   <= n_minutes;
                r_seconds   <= n_seconds;
                r_blank     <= n_blank;
                r_elapsed   <= n_elapsed;
                r_led       <= n_led;
                r_last      <= n_last;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.hours         <= n_hours;
            r_out.minutes       <= n_minutes;
            r_out.seconds       <= n_seconds;
            r_out.cursor        <= n_cursor;
            r_out.field_blanked <= n_blank;
            r_out.led_on        <= n_led;
            r_out.last_button   <= n_last;
        end
    end

endmodule
